// File: sv/tpig_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Terrain patch index generator package
// Shared widths, operation codes, job record and the triangle step tables.
// -----------------------------------------------------------------------------
package tpig_pkg;

   localparam int IDX_W     = 16;   // vertex index width, wraps here
   localparam int OP_W      = 3;
   localparam int LEVEL_W   = 3;
   localparam int CELL_W    = 7;
   localparam int WIDTH_W   = 8;    // patch_width register
   localparam int STRIDE_W  = WIDTH_W + 1;
   localparam int MAX_LEVEL = 6;
   localparam int MAX_BEATS = 9;
   localparam int POS_W     = $clog2(MAX_BEATS);
   localparam int QUEUE_DEPTH = 4;  // power of two

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(64);

   localparam logic [OP_W-1:0] OP_INTERIOR     = 3'd0;
   localparam logic [OP_W-1:0] OP_TOP_SAME     = 3'd1;
   localparam logic [OP_W-1:0] OP_TOP_FINER    = 3'd2;
   localparam logic [OP_W-1:0] OP_TOP_COARSER  = 3'd3;
   localparam logic [OP_W-1:0] OP_LEFT_SAME    = 3'd4;
   localparam logic [OP_W-1:0] OP_LEFT_FINER   = 3'd5;
   localparam logic [OP_W-1:0] OP_LEFT_COARSER = 3'd6;

   // Triangle list shapes.
   typedef enum logic [2:0] {
      PAT_SQUARE,
      PAT_TOP_FAN,
      PAT_LEFT_FAN,
      PAT_TOP_FINER,
      PAT_LEFT_FINER,
      PAT_TOP_COARSER,
      PAT_LEFT_COARSER,
      PAT_REJECT
   } pattern_type;

   localparam int PATTERN_COUNT = 8;

   // Offset added to a row or column base: none, t/2, t or 2t.
   typedef enum logic [1:0] {
      D_ZERO,
      D_HALF,
      D_STEP,
      D_DOUBLE
   } delta_type;

   typedef struct packed {
      delta_type row_delta;
      delta_type col_delta;
   } step_type;

   typedef struct packed {
      pattern_type        pattern;
      logic [LEVEL_W-1:0] level;
      logic [IDX_W-1:0]   row_base;
      logic [IDX_W-1:0]   col_base;
   } job_type;

   localparam step_type ZZ = '{D_ZERO,   D_ZERO};
   localparam step_type ZH = '{D_ZERO,   D_HALF};
   localparam step_type ZS = '{D_ZERO,   D_STEP};
   localparam step_type ZD = '{D_ZERO,   D_DOUBLE};
   localparam step_type SZ = '{D_STEP,   D_ZERO};
   localparam step_type SS = '{D_STEP,   D_STEP};
   localparam step_type SD = '{D_STEP,   D_DOUBLE};
   localparam step_type HZ = '{D_HALF,   D_ZERO};
   localparam step_type DZ = '{D_DOUBLE, D_ZERO};
   localparam step_type DS = '{D_DOUBLE, D_STEP};

   localparam step_type PATTERN_TABLE [PATTERN_COUNT][MAX_BEATS] = '{
      '{ZZ, ZS, SZ, SZ, ZS, SS, ZZ, ZZ, ZZ},   // square
      '{ZZ, ZD, SS, ZD, SD, SS, ZZ, ZZ, ZZ},   // top fan
      '{ZZ, SS, DZ, SS, DS, DZ, ZZ, ZZ, ZZ},   // left fan
      '{ZZ, SS, SZ, ZD, SD, SS, ZZ, ZD, SS},   // top finer
      '{ZZ, ZS, SS, SS, DS, DZ, ZZ, SS, DZ},   // left finer
      '{ZZ, ZH, SZ, ZH, ZS, SS, ZH, SS, SZ},   // top coarser
      '{ZZ, ZS, HZ, HZ, SS, SZ, ZS, SS, HZ},   // left coarser
      '{ZZ, ZZ, ZZ, ZZ, ZZ, ZZ, ZZ, ZZ, ZZ}    // reject
   };

   localparam logic [POS_W-1:0] PATTERN_LEN [PATTERN_COUNT] = '{
      POS_W'(6), POS_W'(6), POS_W'(6), POS_W'(9),
      POS_W'(9), POS_W'(9), POS_W'(9), POS_W'(1)
   };

   function automatic logic [IDX_W-1:0] delta_value(delta_type d,
                                                    logic [LEVEL_W-1:0] level);
      logic [IDX_W-1:0] step;
      logic [IDX_W-1:0] result;
      step = IDX_W'(1) << level;
      case (d)
         D_ZERO:   result = '0;
         D_HALF:   result = step >> 1;
         D_STEP:   result = step;
         D_DOUBLE: result = step << 1;
         default:  result = '0;
      endcase
      return result;
   endfunction

endpackage

// File: sv/tpig_req_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one grid-cell request per beat.
// -----------------------------------------------------------------------------
interface tpig_req_if;
   import tpig_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [LEVEL_W-1:0] level;
   logic [CELL_W-1:0]  cell_row;
   logic [CELL_W-1:0]  cell_col;

   modport source (output valid, operation, level, cell_row, cell_col, input ready);
   modport sink   (input valid, operation, level, cell_row, cell_col, output ready);
endinterface

// File: sv/tpig_rsp_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one vertex index per beat.
// -----------------------------------------------------------------------------
interface tpig_rsp_if;
   import tpig_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] vertex_index;
   logic             last;
   logic             out_of_range;

   modport source (output valid, vertex_index, last, out_of_range, input ready);
   modport sink   (input valid, vertex_index, last, out_of_range, output ready);
endinterface

// File: sv/tpig_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Request classifier
// Checks bounds, picks the triangle shape and computes the row/column base.
// -----------------------------------------------------------------------------
module tpig_front (
   tpig_req_if.sink                      req_chan,
   input  logic [tpig_pkg::WIDTH_W-1:0]  patch_width,
   input  logic                          push_ready,
   output logic                          push_valid,
   output tpig_pkg::job_type             push_job
);
   import tpig_pkg::*;

   logic [IDX_W-1:0] step;
   logic [IDX_W-1:0] half;
   logic [IDX_W-1:0] row_step;
   logic [IDX_W-1:0] col_step;
   logic [IDX_W-1:0] width_ext;
   logic [IDX_W-1:0] row_base;
   logic [IDX_W-1:0] col_base;
   logic             accept;
   pattern_type      pattern;

   assign step      = IDX_W'(1) << req_chan.level;
   assign half      = step >> 1;
   assign row_step  = IDX_W'(req_chan.cell_row) << req_chan.level;
   assign col_step  = IDX_W'(req_chan.cell_col) << req_chan.level;
   assign width_ext = IDX_W'(patch_width);

   always_comb begin
      row_base = '0;
      col_base = '0;
      pattern  = PAT_REJECT;
      accept   = 1'b0;
      unique case (req_chan.operation)
         OP_INTERIOR: begin
            row_base = step + row_step;
            col_base = step + col_step;
            pattern  = PAT_SQUARE;
            accept   = (req_chan.level <= LEVEL_W'(MAX_LEVEL)) &&
                       (row_base < width_ext) && (col_base < width_ext);
         end
         OP_TOP_SAME: begin
            col_base = col_step;
            pattern  = PAT_SQUARE;
            accept   = (req_chan.level < LEVEL_W'(MAX_LEVEL)) && (col_base < width_ext);
         end
         OP_LEFT_SAME: begin
            row_base = row_step;
            pattern  = PAT_SQUARE;
            accept   = (req_chan.level < LEVEL_W'(MAX_LEVEL)) && (row_base < width_ext);
         end
         OP_TOP_FINER: begin
            // first cell is a fan and never out of bounds
            if (req_chan.cell_col == '0) begin
               pattern = PAT_TOP_FAN;
               accept  = (req_chan.level < LEVEL_W'(MAX_LEVEL));
            end else begin
               col_base = col_step << 1;
               pattern  = PAT_TOP_FINER;
               accept   = (req_chan.level < LEVEL_W'(MAX_LEVEL)) && (col_base < width_ext);
            end
         end
         OP_LEFT_FINER: begin
            if (req_chan.cell_row == '0) begin
               pattern = PAT_LEFT_FAN;
               accept  = (req_chan.level < LEVEL_W'(MAX_LEVEL));
            end else begin
               row_base = row_step << 1;
               pattern  = PAT_LEFT_FINER;
               accept   = (req_chan.level < LEVEL_W'(MAX_LEVEL)) && (row_base < width_ext);
            end
         end
         OP_TOP_COARSER: begin
            col_base = col_step;
            pattern  = PAT_TOP_COARSER;
            accept   = (req_chan.level != '0) && (req_chan.level <= LEVEL_W'(MAX_LEVEL)) &&
                       ((col_base + half) < width_ext);
         end
         OP_LEFT_COARSER: begin
            row_base = row_step;
            pattern  = PAT_LEFT_COARSER;
            accept   = (req_chan.level != '0) && (req_chan.level <= LEVEL_W'(MAX_LEVEL)) &&
                       ((row_base + half) < width_ext);
         end
         default: begin
            accept = 1'b0;
         end
      endcase
   end

   // Rejected cells run the one-beat pattern on zero bases, giving index zero.
   always_comb begin
      push_job.level    = req_chan.level;
      push_job.pattern  = accept ? pattern  : PAT_REJECT;
      push_job.row_base = accept ? row_base : '0;
      push_job.col_base = accept ? col_base : '0;
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

// File: sv/tpig_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Job queue
// Small FIFO of classified jobs between the classifier and the sequencer.
// -----------------------------------------------------------------------------
module tpig_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tpig_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tpig_pkg::job_type pop_job
);
   import tpig_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/tpig_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Index sequencer
// Walks a job's step table one beat per cycle unless the response port stalls, forming row*stride + column.
// -----------------------------------------------------------------------------
module tpig_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tpig_pkg::WIDTH_W-1:0]  patch_width,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  tpig_pkg::job_type             pop_job,
   tpig_rsp_if.source                    rsp_chan
);
   import tpig_pkg::*;

   localparam int PROD_W = IDX_W + STRIDE_W;

   step_type          step;
   logic              is_last;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              beat_valid_ff, beat_valid_in;
   logic [IDX_W-1:0]  beat_row_ff;
   logic [IDX_W-1:0]  beat_col_ff;
   logic              beat_last_ff;
   logic              beat_oor_ff;
   logic              out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]  out_index_ff;
   logic              out_last_ff;
   logic              out_oor_ff;
   logic [STRIDE_W-1:0] stride;
   logic [PROD_W-1:0] product;
   logic              out_load;
   logic              beat_load;

   assign step    = PATTERN_TABLE[pop_job.pattern][pos_ff];
   assign is_last = (pos_ff == PATTERN_LEN[pop_job.pattern] - POS_W'(1));

   // Fill a stage when it is empty or drains in the same cycle.
   assign out_load  = beat_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign beat_load = pop_valid && (!beat_valid_ff || out_load);
   assign pop_ready = beat_load && is_last;

   always_comb begin
      pos_in = pos_ff;
      if (beat_load) begin
         pos_in = is_last ? '0 : pos_ff + POS_W'(1);
      end
      beat_valid_in = beat_load || (beat_valid_ff && !out_load);
      out_valid_in  = out_load || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         beat_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         beat_valid_ff <= beat_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_load) begin
         beat_row_ff  <= pop_job.row_base + delta_value(step.row_delta, pop_job.level);
         beat_col_ff  <= pop_job.col_base + delta_value(step.col_delta, pop_job.level);
         beat_last_ff <= is_last;
         beat_oor_ff  <= (pop_job.pattern == PAT_REJECT);
      end
   end

   assign stride  = STRIDE_W'(patch_width) + STRIDE_W'(1);
   assign product = PROD_W'(beat_row_ff) * PROD_W'(stride);

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_index_ff <= product[IDX_W-1:0] + beat_col_ff;
         out_last_ff  <= beat_last_ff;
         out_oor_ff   <= beat_oor_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.vertex_index = out_index_ff;
   assign rsp_chan.last         = out_last_ff;
   assign rsp_chan.out_of_range = out_oor_ff;

endmodule

// File: sv/terrain_patch_index_generator_top.sv
`timescale 1ns / 1ps
// Each request beat names one grid cell of a square terrain patch, a stitching
// variant and a detail level (step t = 2^level); the block answers with that
// cell's triangle vertex indices into a vertex grid of stride patch_width + 1,
// one index per response beat, with last set on the final beat of the cell.
// Interior and same-level edge cells give 6 beats, finer and coarser stitching
// cells give 9, the first finer cell is a 6-beat fan, and a rejected request
// (cell past its bound, level out of range, unused operation code) gives one
// beat with index zero and out_of_range set. The response port moves one index
// per clock while ready is not held low, and cells follow each other with no
// gap while the next is queued; the index sequencer sets this rate. A request
// passes the job queue and the sequencer's beat and output registers before
// its first index is valid. Write patch_width only while the block is idle.
// -----------------------------------------------------------------------------
// Terrain patch index generator, top level
// Classifier, job queue and index sequencer plus the patch width register.
// -----------------------------------------------------------------------------
module terrain_patch_index_generator_top (
   input  logic                          clock,
   input  logic                          reset,
   tpig_req_if.sink                      req_chan,
   tpig_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [tpig_pkg::WIDTH_W-1:0]  csr_write_data
);
   import tpig_pkg::*;

   logic [WIDTH_W-1:0] patch_width_ff, patch_width_in;

   // Classifier to queue.
   logic    push_valid;
   logic    push_ready;
   job_type push_job;

   // Queue to sequencer.
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   // Hold the width unless software writes it.
   assign patch_width_in = csr_write_enable ? csr_write_data : patch_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         patch_width_ff <= WIDTH_RESET;
      end else begin
         patch_width_ff <= patch_width_in;
      end
   end

   // Classify each request and compute its row and column bases.
   tpig_front u_front (
      .req_chan    (req_chan),
      .patch_width (patch_width_ff),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   // Decouple request acceptance from index emission.
   tpig_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Emit one index per beat; drop the job on its last beat.
   tpig_back u_back (
      .clock       (clock),
      .reset       (reset),
      .patch_width (patch_width_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .rsp_chan    (rsp_chan)
   );

endmodule
